// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the timer queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication in the same cycle
`define STQ_ASSERT_SAME(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// check an implication in the next cycle
`define STQ_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/stq_pkg.sv -----
// Shared types and constants for the sorted timer queue
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int ID_BITS_DEF = 8;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int EXP_W       = 32;
    localparam int ID_PORT_W   = 8;
    localparam int OPC_W       = 2;
    localparam int STAT_W      = 3;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } opcode_t;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EXPIRED   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NONE      = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REINS,
        ST_TICK
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        logic any_match;
        logic full;
        logic tail_open;
        logic head_expired;
        logic next_expired;
    } chain_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sorted_timer_queue.sv -----
// Sorted timer queue top level: command sequencer, cell chain and output register.
// A command goes from idle to the execute state, or to the tick state; each result is registered.
// Insert, delete and pop shift the cell chain; adjust removes in execute and reinserts in reinsert.
// Tick emits one result per expired timer popped (one none_expired result when nothing expired,
// at most 32 pops); a held output stalls each result. A new command is taken after the last result.
// Reset clears all slot valid bits, the sequencer and the output valid bit at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [OPC_W-1:0]     opcode,
    input  wire logic [ID_PORT_W-1:0] timer_id,
    input  wire logic [EXP_W-1:0]     expire_time,
    input  wire logic [EXP_W-1:0]     now,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STAT_W-1:0]         status,
    output logic [ID_PORT_W-1:0]      fired_id,
    output logic                      last
);

    localparam int IDX_W = (ID_BITS > ID_PORT_W) ? ID_BITS : ID_PORT_W;

    state_t              state_reg;
    state_t              state_next;
    opcode_t             op_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [EXP_W-1:0]    key_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [ID_PORT_W-1:0] fired_id_reg;
    logic                last_reg;

    logic                out_free;
    logic                emit;
    logic [STAT_W-1:0]   emit_status;
    logic [ID_BITS-1:0]  emit_id;
    logic                emit_last;
    cell_op_t            cell_op;
    chain_stat_t         chain_stat;
    logic [ID_BITS-1:0]  head_id;
    logic [IDX_W-1:0]    id_in_ext;
    logic [IDX_W-1:0]    id_out_ext;

    assign id_in_ext  = IDX_W'(timer_id);
    assign id_out_ext = IDX_W'(emit_id);
    assign out_free   = !out_valid_reg || out_ready;

    stq_chain #(
        .DEPTH  (DEPTH),
        .ID_BITS(ID_BITS)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cell_op(cell_op),
        .key_id (id_reg),
        .key_exp(key_reg),
        .stat   (chain_stat),
        .head_id(head_id)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cell_op     = CELL_HOLD;
        emit        = 1'b0;
        emit_status = STAT_OK;
        emit_id     = id_reg;
        emit_last   = 1'b1;
        in_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (opcode_t'(opcode) == OP_TICK) ? ST_TICK : ST_EXEC;
                    cnt_next   = '0;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (chain_stat.any_match)
                            begin
                                emit_status = STAT_DUPLICATE;
                            end
                            else if (chain_stat.full)
                            begin
                                emit_status = STAT_FULL;
                            end
                            else
                            begin
                                cell_op = CELL_INSERT;
                            end
                        end
                        OP_ADJUST, OP_DELETE:
                        begin
                            if (!chain_stat.any_match)
                            begin
                                emit_status = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                cell_op = CELL_REMOVE;
                                if (op_reg == OP_ADJUST)
                                begin
                                    emit       = 1'b0;
                                    state_next = ST_REINS;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REINS:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    cell_op    = CELL_INSERT;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (chain_stat.head_expired)
                    begin
                        cell_op     = CELL_POP;
                        emit_status = STAT_EXPIRED;
                        emit_id     = head_id;
                        emit_last   = !chain_stat.next_expired
                                      || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                        cnt_next    = cnt_reg + 1'b1;
                        if (emit_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        emit_status = STAT_NONE;
                        emit_id     = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= opcode_t'(opcode);
            id_reg  <= id_in_ext[ID_BITS-1:0];
            key_reg <= (opcode_t'(opcode) == OP_TICK) ? now : expire_time;
        end
        if (emit)
        begin
            status_reg   <= emit_status;
            fired_id_reg <= id_out_ext[ID_PORT_W-1:0];
            last_reg     <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign fired_id  = fired_id_reg;
    assign last      = last_reg;

    `STQ_ASSERT_SAME(a_insert_never_when_full, cell_op == CELL_INSERT, chain_stat.tail_open, "insert into full chain")
    `STQ_ASSERT_SAME(a_none_only_first, emit && emit_status == STAT_NONE, cnt_reg == '0 && state_reg == ST_TICK, "none_expired after a pop")
    `STQ_ASSERT_NEXT(a_last_returns_idle, emit && emit_last, state_reg == ST_IDLE, "sequencer busy after final transaction")
    `STQ_ASSERT_SAME(a_no_emit_while_blocked, out_valid_reg && !out_ready, !emit, "result overwritten while held")

endmodule

`default_nettype wire

// ----- rtl/core/stq_cell.sv -----
// One slot of the sorted timer chain: holds a timer and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module stq_cell
    import stq_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_op_t           cell_op,
    input  wire logic [ID_BITS-1:0] key_id,
    input  wire logic [EXP_W-1:0]   key_exp,
    input  wire logic               prev_valid,
    input  wire logic [EXP_W-1:0]   prev_exp,
    input  wire logic [ID_BITS-1:0] prev_id,
    input  wire logic               prev_open,
    input  wire logic               prev_after,
    input  wire logic               next_valid,
    input  wire logic [EXP_W-1:0]   next_exp,
    input  wire logic [ID_BITS-1:0] next_id,
    output logic                    valid,
    output logic [EXP_W-1:0]        expiry,
    output logic [ID_BITS-1:0]      ident,
    output logic                    open,
    output logic                    after
);

    logic               valid_reg;
    logic               valid_next;
    logic [EXP_W-1:0]   expiry_reg;
    logic [EXP_W-1:0]   expiry_next;
    logic [ID_BITS-1:0] ident_reg;
    logic [ID_BITS-1:0] ident_next;
    logic               match;

    assign open   = !valid_reg || (expiry_reg > key_exp);
    assign match  = valid_reg && (ident_reg == key_id);
    assign after  = prev_after || match;
    assign valid  = valid_reg;
    assign expiry = expiry_reg;
    assign ident  = ident_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        expiry_next = expiry_reg;
        ident_next  = ident_reg;
        case (cell_op)
            CELL_INSERT:
            begin
                if (prev_open)
                begin
                    valid_next  = prev_valid;
                    expiry_next = prev_exp;
                    ident_next  = prev_id;
                end
                else if (open)
                begin
                    valid_next  = 1'b1;
                    expiry_next = key_exp;
                    ident_next  = key_id;
                end
            end
            CELL_REMOVE:
            begin
                if (after)
                begin
                    valid_next  = next_valid;
                    expiry_next = next_exp;
                    ident_next  = next_id;
                end
            end
            CELL_POP:
            begin
                valid_next  = next_valid;
                expiry_next = next_exp;
                ident_next  = next_id;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        ident_reg  <= ident_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/stq_chain.sv -----
// Row of timer cells kept in ascending expiry order
`timescale 1ns / 1ps
`default_nettype none

module stq_chain
    import stq_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_op_t           cell_op,
    input  wire logic [ID_BITS-1:0] key_id,
    input  wire logic [EXP_W-1:0]   key_exp,
    output chain_stat_t             stat,
    output logic [ID_BITS-1:0]      head_id
);

    // index i+1 holds cell i; both ends read as empty
    logic               valid_a [DEPTH+2];
    logic [EXP_W-1:0]   exp_a   [DEPTH+2];
    logic [ID_BITS-1:0] id_a    [DEPTH+2];
    logic               open_a  [DEPTH+1];
    logic               after_a [DEPTH+1];

    assign valid_a[0]       = 1'b0;
    assign exp_a[0]         = '0;
    assign id_a[0]          = '0;
    assign valid_a[DEPTH+1] = 1'b0;
    assign exp_a[DEPTH+1]   = '0;
    assign id_a[DEPTH+1]    = '0;
    assign open_a[0]        = 1'b0;
    assign after_a[0]       = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        stq_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_op    (cell_op),
            .key_id     (key_id),
            .key_exp    (key_exp),
            .prev_valid (valid_a[i]),
            .prev_exp   (exp_a[i]),
            .prev_id    (id_a[i]),
            .prev_open  (open_a[i]),
            .prev_after (after_a[i]),
            .next_valid (valid_a[i+2]),
            .next_exp   (exp_a[i+2]),
            .next_id    (id_a[i+2]),
            .valid      (valid_a[i+1]),
            .expiry     (exp_a[i+1]),
            .ident      (id_a[i+1]),
            .open       (open_a[i+1]),
            .after      (after_a[i+1])
        );
    end

    assign stat.any_match    = after_a[DEPTH];
    assign stat.full         = valid_a[DEPTH];
    assign stat.tail_open    = open_a[DEPTH];
    assign stat.head_expired = valid_a[1] && !open_a[1];
    assign stat.next_expired = valid_a[2] && !open_a[2];
    assign head_id           = id_a[1];

endmodule

`default_nettype wire

// ----- tb/tb_sorted_timer_queue.sv -----
// Testbench for the sorted timer queue: directed and random commands checked against a sorted list
`timescale 1ns / 1ps

module tb_sorted_timer_queue
    import stq_pkg::*;
();

    localparam int QUEUE_DEPTH     = DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [ID_PORT_W-1:0] fired_id;
        logic                 last;
    } timer_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [OPC_W-1:0]     opcode      = '0;
    logic [ID_PORT_W-1:0] timer_id    = '0;
    logic [EXP_W-1:0]     expire_time = '0;
    logic [EXP_W-1:0]     now         = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [STAT_W-1:0]    status;
    logic [ID_PORT_W-1:0] fired_id;
    logic                 last;

    logic [EXP_W-1:0]     held_expiry [QUEUE_DEPTH];
    logic [ID_PORT_W-1:0] held_id     [QUEUE_DEPTH];
    int                   held_count  = 0;
    timer_result_t        pending_results [$];

    int                   error_count  = 0;
    int                   quiet_cycles = 0;
    bit                   idle_enable  = 1'b0;
    bit                   hold_request = 1'b0;
    logic [EXP_W-1:0]     wall_time    = '0;

    sorted_timer_queue DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .timer_id    (timer_id),
        .expire_time (expire_time),
        .now         (now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .fired_id    (fired_id),
        .last        (last)
    );

    always #1 clk = ~clk;

    function automatic int find_timer(input logic [ID_PORT_W-1:0] id);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_id[i] == id)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void drop_slot(input int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_expiry[i] = held_expiry[i + 1];
            held_id[i]     = held_id[i + 1];
        end
        held_count--;
    endfunction

    function automatic void place_timer(input logic [ID_PORT_W-1:0] id,
                                        input logic [EXP_W-1:0] exp);
        int pos;
        pos = 0;
        while (pos < held_count && held_expiry[pos] <= exp)
        begin
            pos++;
        end
        for (int i = held_count; i > pos; i--)
        begin
            held_expiry[i] = held_expiry[i - 1];
            held_id[i]     = held_id[i - 1];
        end
        held_expiry[pos] = exp;
        held_id[pos]     = id;
        held_count++;
    endfunction

    function automatic void push_result(input logic [STAT_W-1:0] st,
                                        input logic [ID_PORT_W-1:0] id,
                                        input logic lst);
        timer_result_t r;
        r.status   = st;
        r.fired_id = id;
        r.last     = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_command(input opcode_t op,
                                          input logic [ID_PORT_W-1:0] id,
                                          input logic [EXP_W-1:0] exp,
                                          input logic [EXP_W-1:0] t_now);
        int slot;
        int n;
        case (op)
            OP_INSERT:
            begin
                if (find_timer(id) >= 0)
                begin
                    push_result(STAT_DUPLICATE, id, 1'b1);
                end
                else if (held_count >= QUEUE_DEPTH)
                begin
                    push_result(STAT_FULL, id, 1'b1);
                end
                else
                begin
                    place_timer(id, exp);
                    push_result(STAT_OK, id, 1'b1);
                end
            end
            OP_ADJUST, OP_DELETE:
            begin
                slot = find_timer(id);
                if (slot < 0)
                begin
                    push_result(STAT_NOT_FOUND, id, 1'b1);
                end
                else
                begin
                    drop_slot(slot);
                    if (op == OP_ADJUST)
                    begin
                        place_timer(id, exp);
                    end
                    push_result(STAT_OK, id, 1'b1);
                end
            end
            default:
            begin
                n = 0;
                while (n < MAX_RESULTS && n < held_count && held_expiry[n] <= t_now)
                begin
                    n++;
                end
                if (n == 0)
                begin
                    push_result(STAT_NONE, '0, 1'b1);
                end
                for (int k = 0; k < n; k++)
                begin
                    push_result(STAT_EXPIRED, held_id[0], k == n - 1);
                    drop_slot(0);
                end
            end
        endcase
    endfunction

    task automatic send_command(input opcode_t op, input logic [ID_PORT_W-1:0] id,
                                input logic [EXP_W-1:0] exp, input logic [EXP_W-1:0] t_now);
        in_valid    <= 1'b1;
        opcode      <= op;
        timer_id    <= id;
        expire_time <= exp;
        now         <= t_now;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        apply_command(op, id, exp, t_now);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transaction: status=%0d fired_id=%0d last=%0d",
                         $time, status, fired_id, last);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("fired_id", 32'(want.fired_id), 32'(fired_id));
                compare_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [ID_PORT_W-1:0] pick_held_id();
        return held_id[$urandom_range(0, held_count - 1)];
    endfunction

    function automatic logic [EXP_W-1:0] random_expiry();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return wall_time;
            default: return wall_time + $urandom_range(1, 40);
        endcase
    endfunction

    task automatic random_command();
        int                   pick;
        opcode_t              op;
        logic [ID_PORT_W-1:0] id;
        logic [EXP_W-1:0]     exp;
        logic [EXP_W-1:0]     t_now;
        pick  = $urandom_range(0, 99);
        id    = ID_PORT_W'($urandom_range(0, 255));
        exp   = random_expiry();
        t_now = $urandom;
        if (pick < 38)
        begin
            op = OP_INSERT;
        end
        else if (pick < 58)
        begin
            op = OP_ADJUST;
        end
        else if (pick < 72)
        begin
            op = OP_DELETE;
        end
        else
        begin
            op = OP_TICK;
        end
        if (held_count < 4 && op != OP_TICK && $urandom_range(0, 1) == 0)
        begin
            op = OP_INSERT;
        end
        if (held_count > 0 && op == OP_INSERT && $urandom_range(0, 9) == 0)
        begin
            id = pick_held_id();
        end
        if (held_count > 0 && (op == OP_ADJUST || op == OP_DELETE) && $urandom_range(0, 9) != 0)
        begin
            id = pick_held_id();
        end
        if (op == OP_TICK)
        begin
            case ($urandom_range(0, 19))
                0: t_now = $urandom;
                1: t_now = '1;
                default:
                begin
                    wall_time = wall_time + $urandom_range(0, 24);
                    t_now     = wall_time;
                end
            endcase
        end
        send_command(op, id, exp, t_now);
    endtask

    task automatic test_empty_queue();
        send_command(OP_TICK, 8'd0, 32'd0, 32'd0);
        send_command(OP_DELETE, 8'd255, 32'd0, 32'hFFFF_FFFF);
        send_command(OP_ADJUST, 8'd0, 32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic test_ordering_and_ties();
        send_command(OP_INSERT, 8'd0, 32'd0, 32'd0);
        send_command(OP_INSERT, 8'd255, 32'hFFFF_FFFF, 32'd0);
        send_command(OP_INSERT, 8'd0, 32'd5, 32'd0);
        send_command(OP_INSERT, 8'd128, 32'hFFFF_FFFF, 32'd0);
        send_command(OP_INSERT, 8'd1, 32'd0, 32'd0);
        send_command(OP_ADJUST, 8'd255, 32'd3, 32'd0);
        send_command(OP_ADJUST, 8'd0, 32'd10, 32'd0);
        send_command(OP_DELETE, 8'd1, 32'd0, 32'd0);
        send_command(OP_ADJUST, 8'd128, 32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic test_expiry_ticks();
        send_command(OP_TICK, 8'd0, 32'd0, 32'd2);
        send_command(OP_TICK, 8'd0, 32'd0, 32'd3);
        send_command(OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFE);
        send_command(OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_command(OP_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_queue();
        logic [ID_PORT_W-1:0] base;
        base = ID_PORT_W'($urandom_range(0, 255));
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            send_command(OP_INSERT, base + 8'(i * 7), wall_time + $urandom_range(0, 3),
                         $urandom);
        end
        send_command(OP_INSERT, base + 8'(QUEUE_DEPTH * 7), random_expiry(), $urandom);
        send_command(OP_INSERT, pick_held_id(), random_expiry(), $urandom);
        send_command(OP_ADJUST, pick_held_id(), wall_time, $urandom);
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        send_command(OP_TICK, ID_PORT_W'($urandom_range(0, 255)), $urandom, 32'hFFFF_FFFF);
        repeat (12)
        begin
            send_command(OP_INSERT, ID_PORT_W'($urandom_range(0, 255)), random_expiry(),
                         $urandom);
        end
        send_command(OP_TICK, ID_PORT_W'($urandom_range(0, 255)), $urandom, wall_time + 20);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) random_command();
    endtask

    task automatic test_back_to_back(input int count);
        idle_enable = 1'b0;
        repeat (count) random_command();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wall_time = $urandom_range(0, 1000);

        test_empty_queue();
        test_ordering_and_ties();
        test_expiry_ticks();
        wait_for_results();

        idle_enable = 1'b1;
        test_full_queue();
        test_output_backpressure();
        test_random_traffic(170);
        wait_for_results();
        test_random_traffic(170);
        test_back_to_back(70);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
